>>> src/sbbh_pkg.sv
// Shared types, constants and functions for the spectrum bin to bar height block.
// Used by sbbh_isqrt_pipe and spectrum_bin_to_bar_height_top; depends on nothing.
`default_nettype none

package sbbh_pkg;

    localparam int FFT_POINTS = 256;

    localparam int BIN_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;   // largest square is 2^30
    localparam int RAD_W    = 2 * SAMPLE_W;       // sum of two squares
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int BAR_W    = 5;
    localparam int HEIGHT_W = 6;

    localparam int NUM_BARS  = 25;
    localparam int LOW_BARS  = 11;
    localparam int HIGH_BARS = NUM_BARS - LOW_BARS;

    localparam int SQRT_STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

    localparam logic [HIGH_BARS-1:0][BIN_W-1:0] HIGH_BINS = {
        8'd115, 8'd90, 8'd77, 8'd64, 8'd51, 8'd45, 8'd38,
        8'd32, 8'd29, 8'd26, 8'd23, 8'd19, 8'd16, 8'd13
    };

    // Halvings of the transform size needed to reach 128 or less
    function automatic int mag_shift_f(input int n);
        int m;
        int s;
        m = n;
        s = 0;
        while (m > 128 && s < 31) begin
            m = m / 2;
            s = s + 1;
        end
        return s;
    endfunction

    localparam int MAG_SHIFT = mag_shift_f(FFT_POINTS);

    typedef struct packed {
        logic             sel;
        logic [BAR_W-1:0] index;
        logic             last;
    } bar_sel_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_state_t;

    function automatic bar_sel_t bar_of_bin(input logic [BIN_W-1:0] bin);
        bar_sel_t b;
        b.sel   = 1'b0;
        b.index = '0;
        b.last  = 1'b0;
        if (bin >= BIN_W'(1) && bin <= BIN_W'(LOW_BARS)) begin
            b.sel   = 1'b1;
            b.index = BAR_W'(bin - BIN_W'(1));
        end
        for (int k = 0; k < HIGH_BARS; k++) begin
            if (HIGH_BINS[k] == bin) begin
                b.sel   = 1'b1;
                b.index = BAR_W'(LOW_BARS + k);
            end
        end
        b.last = b.sel && (b.index == BAR_W'(NUM_BARS - 1));
        return b;
    endfunction

    // Restoring square root, two radicand bits per step
    function automatic sqrt_state_t sqrt_steps(input sqrt_state_t s);
        sqrt_state_t        t;
        logic [REM_W:0]     rem_w;
        logic [REM_W:0]     trial;
        t = s;
        for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
            rem_w = {t.rem[REM_W-2:0], t.rad[RAD_W-1 -: 2]};
            trial = {1'b0, t.root, 2'b01};
            t.rad = {t.rad[RAD_W-3:0], 2'b00};
            if (rem_w >= trial) begin
                t.rem  = REM_W'(rem_w - trial);
                t.root = {t.root[ROOT_W-2:0], 1'b1};
            end else begin
                t.rem  = rem_w[REM_W-1:0];
                t.root = {t.root[ROOT_W-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    function automatic logic [HEIGHT_W-1:0] compress(input logic [ROOT_W-1:0] v);
        logic [HEIGHT_W-1:0] h;
        if (v == '0)
            h = HEIGHT_W'(2);
        else if (v < ROOT_W'(5))
            h = HEIGHT_W'(v + ROOT_W'(7));
        else if (v < ROOT_W'(10))
            h = HEIGHT_W'(v + ROOT_W'(5));
        else if (v < ROOT_W'(15))
            h = HEIGHT_W'(v + ROOT_W'(4));
        else if (v >= ROOT_W'(64))
            h = HEIGHT_W'(63);
        else if (v >= ROOT_W'(55))
            h = HEIGHT_W'(v - ROOT_W'(8));
        else
            h = v[HEIGHT_W-1:0];
        return h;
    endfunction

endpackage

`default_nettype wire

>>> src/sbbh_isqrt_pipe.sv
// Pipelined integer square root of a 32-bit sum of squares, four root bits per stage.
// Carries the bar selection alongside; uses sbbh_pkg.
`default_nettype none

module sbbh_isqrt_pipe (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sbbh_pkg::RAD_W-1:0]     in_rad,
    input  wire sbbh_pkg::bar_sel_t             in_bar,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sbbh_pkg::ROOT_W-1:0]         out_root,
    output sbbh_pkg::bar_sel_t                  out_bar
);

    localparam int N = sbbh_pkg::SQRT_STAGES;

    logic                  valid_reg [N];
    sbbh_pkg::sqrt_state_t st_reg    [N];
    sbbh_pkg::bar_sel_t    bar_reg   [N];
    sbbh_pkg::sqrt_state_t st_next   [N];
    logic                  stage_ready [N+1];

    always_comb
    begin
        stage_ready[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        sbbh_pkg::sqrt_state_t seed;
        seed.rem  = '0;
        seed.root = '0;
        seed.rad  = in_rad;
        st_next[0] = sbbh_pkg::sqrt_steps(seed);
        for (int k = 1; k < N; k++) begin
            st_next[k] = sbbh_pkg::sqrt_steps(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < N; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && in_valid) begin
            st_reg[0]  <= st_next[0];
            bar_reg[0] <= in_bar;
        end
        for (int k = 1; k < N; k++) begin
            if (stage_ready[k] && valid_reg[k-1]) begin
                st_reg[k]  <= st_next[k];
                bar_reg[k] <= bar_reg[k-1];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[N-1];
    assign out_root  = st_reg[N-1].root;
    assign out_bar   = bar_reg[N-1];

endmodule

`default_nettype wire

>>> src/spectrum_bin_to_bar_height_top.sv
// Top level: FFT bin in, display bar height out, through squares, sum, root and compress stages.
// Uses sbbh_pkg and sbbh_isqrt_pipe.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: bin_re[15:0] bin_im[31:16] bin_number[39:32]
//  m_*     | out | m_tvalid/m_tready | tdata: bar_index[4:0] bar_height[10:5]; tlast: frame_last
//
//  One item enters per cycle while no stall backs up to the input. A bin passes squares, sum,
//  four square-root stages of four root bits each, then compress into the output register.
//  Bins that map to no bar are accepted and dropped at the first stage.
//  Each stage advances when empty or when the stage after it moves, so a stall at m_tready
//  backs up only as far as the full stages and bubbles are squeezed out.
//  Reset clears the valid bits only; no state links one item to the next.
`default_nettype none

module spectrum_bin_to_bar_height_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // bin_re[15:0], bin_im[31:16], bin_number[39:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // bar_index[4:0], bar_height[10:5], zero[15:11]
    output logic             m_tlast
);

    logic signed [sbbh_pkg::SAMPLE_W-1:0] bin_re;
    logic signed [sbbh_pkg::SAMPLE_W-1:0] bin_im;
    logic [sbbh_pkg::BIN_W-1:0]           bin_number;
    sbbh_pkg::bar_sel_t                   in_bar;

    logic signed [2*sbbh_pkg::SAMPLE_W-1:0] prod_re;
    logic signed [2*sbbh_pkg::SAMPLE_W-1:0] prod_im;

    // Squares stage
    logic                          sq_valid_reg;
    logic [sbbh_pkg::SQ_W-1:0]     sq_re_reg;
    logic [sbbh_pkg::SQ_W-1:0]     sq_im_reg;
    sbbh_pkg::bar_sel_t            sq_bar_reg;
    logic                          sq_ready;

    // Sum stage
    logic                          sum_valid_reg;
    logic [sbbh_pkg::RAD_W-1:0]    sum_reg;
    logic [sbbh_pkg::RAD_W-1:0]    sum_next;
    sbbh_pkg::bar_sel_t            sum_bar_reg;
    logic                          sum_ready;

    // Root pipeline
    logic                          rt_in_ready;
    logic                          rt_valid;
    logic [sbbh_pkg::ROOT_W-1:0]   rt_root;
    sbbh_pkg::bar_sel_t            rt_bar;

    // Output stage
    logic                          out_ready;
    logic                          m_valid_reg;
    logic [sbbh_pkg::BAR_W-1:0]    index_reg;
    logic [sbbh_pkg::HEIGHT_W-1:0] height_reg;
    logic                          last_reg;
    logic [sbbh_pkg::ROOT_W-1:0]   mag;
    logic [sbbh_pkg::ROOT_W-1:0]   scaled;
    logic [sbbh_pkg::HEIGHT_W-1:0] height_next;

    assign bin_re     = s_tdata[15:0];
    assign bin_im     = s_tdata[31:16];
    assign bin_number = s_tdata[39:32];
    assign in_bar     = sbbh_pkg::bar_of_bin(bin_number);

    assign prod_re = bin_re * bin_re;
    assign prod_im = bin_im * bin_im;

    assign out_ready = !m_valid_reg || m_tready;
    assign sum_ready = !sum_valid_reg || rt_in_ready;
    assign sq_ready  = !sq_valid_reg || sum_ready;
    assign s_tready  = sq_ready;

    assign sum_next = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};

    // Magnitude scaled by 4, wrapped to 16 bits
    assign mag         = rt_root >> sbbh_pkg::MAG_SHIFT;
    assign scaled      = {mag[sbbh_pkg::ROOT_W-3:0], 2'b00};
    assign height_next = sbbh_pkg::compress(scaled);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (sq_ready) begin
                // drop bins that feed no bar
                sq_valid_reg <= s_tvalid && in_bar.sel;
            end
            if (sum_ready) begin
                sum_valid_reg <= sq_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= rt_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && s_tvalid) begin
            sq_re_reg  <= prod_re[sbbh_pkg::SQ_W-1:0];
            sq_im_reg  <= prod_im[sbbh_pkg::SQ_W-1:0];
            sq_bar_reg <= in_bar;
        end
        if (sum_ready && sq_valid_reg) begin
            sum_reg     <= sum_next;
            sum_bar_reg <= sq_bar_reg;
        end
        if (out_ready && rt_valid) begin
            index_reg  <= rt_bar.index;
            height_reg <= height_next;
            last_reg   <= rt_bar.last;
        end
    end

    sbbh_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid_reg),
        .in_ready  (rt_in_ready),
        .in_rad    (sum_reg),
        .in_bar    (sum_bar_reg),
        .out_valid (rt_valid),
        .out_ready (out_ready),
        .out_root  (rt_root),
        .out_bar   (rt_bar)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, height_reg, index_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> src/sbbh_checker.sv
// Port-level checks on the spectrum bin to bar height top level, bound to it below.
// Depends on the top level's port list only.
`default_nettype none

module sbbh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled bar holds
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("bar changed or vanished while stalled");

    // Frame end marks bar 24 and only that bar
    a_last_bar: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[4:0] == 5'd24)))
        else $error("tlast does not match bar 24");

    // Bar index in range, padding clear, height never below the floor of 2
    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:0] <= 5'd24 && m_tdata[15:11] == 5'd0 && m_tdata[10:5] >= 6'd2)
        else $error("bar index, height or padding out of range");

    // Empty pipeline after an idle input takes the next bin
    a_accept_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid, 1) && $past(!s_tvalid, 2)
        && $past(!s_tvalid, 3) && $past(!s_tvalid, 4) && $past(!s_tvalid, 5)
        && $past(!s_tvalid, 6) && $past(!s_tvalid, 7) && $past(rst_n, 8) |-> s_tready)
        else $error("input not ready with an empty pipeline");

endmodule

bind spectrum_bin_to_bar_height_top sbbh_checker u_sbbh_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for spectrum_bin_to_bar_height_top: drives FFT bins on the input
// stream and checks every bar item against a local predictor of magnitude and compression.
// Depends on sbbh_pkg and the RTL under src/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_ACCEPT_LIMIT = 4000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int LONG_HOLD       = 300;
    localparam int REPORT_MAX      = 10;

    localparam logic [7:0] HIGH_BIN_LIST [14] = '{
        8'd13, 8'd16, 8'd19, 8'd23, 8'd26, 8'd29, 8'd32,
        8'd38, 8'd45, 8'd51, 8'd64, 8'd77, 8'd90, 8'd115
    };

    typedef struct packed {
        logic [4:0] index;
        logic [5:0] height;
        logic       last;
    } bar_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    bar_t pending_bars [$];
    int   mismatches = 0;
    int   no_accept_cycles = 0;
    int   hold_len = 0;
    bit   send_gaps = 1'b0;
    bit   recv_stalls = 1'b0;

    spectrum_bin_to_bar_height_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Work out the bar a bin produces; returns 0 for bins that are not displayed
    function automatic bit bar_for_bin(input logic [39:0] d, output bar_t b);
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [7:0]         bin;
        longint             sumsq;
        longint             root;
        longint             cand;
        int                 idx;
        int                 n;
        int                 sh;
        logic [15:0]        v;
        re    = d[15:0];
        im    = d[31:16];
        bin   = d[39:32];
        b     = '0;
        idx   = -1;
        if (bin >= 8'd1 && bin <= 8'd11)
            idx = int'(bin) - 1;
        for (int k = 0; k < 14; k++)
            if (HIGH_BIN_LIST[k] == bin)
                idx = 11 + k;
        if (idx < 0)
            return 1'b0;
        sumsq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        root  = 0;
        for (int i = 16; i >= 0; i--)
        begin
            cand = root + (longint'(1) << i);
            if (cand * cand <= sumsq)
                root = cand;
        end
        n  = sbbh_pkg::FFT_POINTS;
        sh = 0;
        while (n > 128 && sh < 31)
        begin
            n  = n / 2;
            sh = sh + 1;
        end
        v = 16'((root >> sh) << 2);
        if (v == 16'd0)
            b.height = 6'd2;
        else if (v < 16'd5)
            b.height = 6'(v + 16'd7);
        else if (v < 16'd10)
            b.height = 6'(v + 16'd5);
        else if (v < 16'd15)
            b.height = 6'(v + 16'd4);
        else if (v >= 16'd64)
            b.height = 6'd63;
        else if (v >= 16'd55)
            b.height = 6'(v - 16'd8);
        else
            b.height = 6'(v);
        b.index = 5'(idx);
        b.last  = (idx == 24);
        return 1'b1;
    endfunction

    // Predict on every accepted bin, compare every accepted bar
    always @(posedge clk)
    begin
        bar_t exp_bar;
        bar_t new_bar;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_bars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected bar item tdata=%h tlast=%b",
                                 $realtime, m_tdata, m_tlast);
                end
                else
                begin
                    exp_bar = pending_bars.pop_front();
                    if (m_tdata[4:0] !== exp_bar.index || m_tdata[10:5] !== exp_bar.height
                        || m_tlast !== exp_bar.last || m_tdata[15:11] !== 5'd0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: bar mismatch exp index=%0d height=%0d last=%b pad=0",
                                     $realtime, exp_bar.index, exp_bar.height, exp_bar.last);
                            $display("%0t:   got index=%0d height=%0d last=%b pad=%0d",
                                     $realtime, m_tdata[4:0], m_tdata[10:5], m_tlast,
                                     m_tdata[15:11]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                if (bar_for_bin(s_tdata, new_bar))
                    pending_bars.push_back(new_bar);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                no_accept_cycles = 0;
            else
                no_accept_cycles++;
            if (no_accept_cycles >= NO_ACCEPT_LIMIT)
            begin
                $display("%0t: no item accepted for %0d cycles", $realtime, NO_ACCEPT_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Output ready: random stall bursts, or one long hold-off on request
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_len != 0)
            begin
                n        = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
            end
            else if (recv_stalls && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 6);
                m_tready <= 1'b0;
            end
            else
            begin
                n = 1;
                m_tready <= 1'b1;
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_bin(input logic [15:0] re, input logic [15:0] im,
                            input logic [7:0] bin);
        s_tvalid <= 1'b1;
        s_tdata  <= {bin, im, re};
        do
            @(posedge clk);
        while (!s_tready);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop valid, wait out every expected bar, then let the pipeline settle
    task automatic drain_bars();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_part();
        logic [15:0] p;
        case ($urandom_range(0, 3))
            0: p = 16'($urandom_range(0, 70));
            1: p = 16'($urandom_range(16300, 16500)) << 1;
            default: p = 16'($urandom);
        endcase
        if ($urandom_range(0, 1))
            p = -p;
        return p;
    endfunction

    function automatic logic [7:0] rand_bin();
        int k;
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        k = $urandom_range(0, 24);
        return (k < 11) ? 8'(k + 1) : HIGH_BIN_LIST[k - 11];
    endfunction

    task automatic test_extremes();
        send_bin(16'd0, 16'd0, 8'd1);
        send_bin(16'h8000, 16'h8000, 8'd115);
        send_bin(16'h7FFF, 16'h7FFF, 8'd11);
        send_bin(16'h8000, 16'd0, 8'd13);
        send_bin(16'd0, 16'h8000, 8'd2);
        send_bin(16'h7FFF, 16'd0, 8'd90);
        send_bin(16'd0, 16'h7FFF, 8'd64);
        send_bin(16'h7FFF, 16'd443, 8'd3);
        send_bin(16'd2, 16'd0, 8'd4);
        send_bin(16'd4, 16'd0, 8'd5);
        send_bin(16'd6, 16'hFFFF, 8'd6);
        send_bin(16'd26, 16'd0, 8'd7);
        send_bin(16'hFFE4, 16'd0, 8'd8);
        send_bin(16'd0, 16'd30, 8'd9);
        send_bin(16'd32, 16'd0, 8'd10);
        send_bin(16'd20, 16'd21, 8'd16);
        // bins with no bar: DC, gaps between bars, past the last bar
        send_bin(16'h1234, 16'h5678, 8'd0);
        send_bin(16'd10, 16'd10, 8'd12);
        send_bin(16'd10, 16'd10, 8'd14);
        send_bin(16'd10, 16'd10, 8'd116);
        send_bin(16'hFFFF, 16'hFFFF, 8'd255);
        send_bin(16'h5555, 16'hAAAA, 8'd115);
        drain_bars();
    endtask

    task automatic test_random_bins();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        for (int i = 0; i < 650; i++)
        begin
            // leave stretches free of gaps and stalls
            send_gaps   = (i % 200) < 140;
            recv_stalls = (i % 200) < 140;
            send_bin(rand_part(), rand_part(), rand_bin());
        end
    endtask

    task automatic test_output_hold();
        hold_len = LONG_HOLD;
        for (int i = 0; i < 60; i++)
            send_bin(rand_part(), rand_part(), 8'($urandom_range(1, 11)));
    endtask

    task automatic test_pause_until_empty();
        drain_bars();
        for (int i = 0; i < 80; i++)
            send_bin(rand_part(), rand_part(), rand_bin());
        drain_bars();
    endtask

    task automatic test_quiet_tail();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        for (int i = 0; i < 200; i++)
            send_bin(rand_part(), rand_part(), rand_bin());
        drain_bars();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_extremes();
        test_random_bins();
        test_output_hold();
        test_pause_until_empty();
        test_quiet_tail();
        if (mismatches == 0 && pending_bars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
